>>> hdl/crps_pkg.sv
package crps_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_SAMPLES = 32;
	localparam int MIN_SAMPLES = 10;

	localparam int CW     = 32;          // coordinate
	localparam int DW     = CW + 1;      // point difference
	localparam int CO_W   = 38;          // cubic coefficients c2, c3
	localparam int MUL_W  = 45;          // c2*m and d0*m^2
	localparam int NUM_W  = 48;          // forward-difference numerators
	localparam int MAG_W  = NUM_W - 1;
	localparam int Q_W    = 48;          // quotient part of a difference
	localparam int DEN_W  = 17;          // 2*m^3
	localparam int R_W    = DEN_W;
	localparam int M_W    = 6;
	localparam int SQ_W   = 2 * CW + 2;  // sum of three squares
	localparam int RT_W   = SQ_W / 2;
	localparam int KT_W   = 38;
	localparam int THR_W  = 32;
	localparam int TDATA_W = 3 * CW;

	localparam logic [THR_W-1:0] THR_RESET = 32'd52429;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;

	typedef struct packed {
		logic              err;
		logic              fin;
		coord_t [2:0]      p0;
		coord_t [2:0]      p1;
		diff_t  [2:0]      d0;
		diff_t  [2:0]      d1;
	} seg_job_t;

	typedef struct packed {
		logic signed [Q_W-1:0] q;
		logic [R_W-1:0]        r;
	} fd_t;

	typedef enum logic [1:0] {F_IDLE, F_PUSH_A, F_PUSH_B} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_ERR, B_SUMSQ, B_SQRT, B_COUNT,
		B_COEF1, B_COEF2, B_COEF3, B_DIV, B_EMIT
	} back_state_t;

	function automatic diff_t pt_sub(coord_t a, coord_t b);
		return {a[CW-1], a} - {b[CW-1], b};
	endfunction

	// quotient/remainder add, remainders both below den
	function automatic fd_t fd_add(fd_t a, fd_t b, logic [DEN_W-1:0] den);
		logic [R_W:0] s;
		fd_t          o;
		s = {1'b0, a.r} + {1'b0, b.r};
		if (s >= {1'b0, den}) begin
			o.r = R_W'(s - {1'b0, den});
			o.q = a.q + b.q + Q_W'(1);
		end else begin
			o.r = s[R_W-1:0];
			o.q = a.q + b.q;
		end
		return o;
	endfunction

	function automatic coord_t sat_coord(logic signed [Q_W:0] v);
		if (v > (Q_W+1)'(signed'(33'sh0_7FFF_FFFF))) return 32'sh7FFF_FFFF;
		else if (v < (Q_W+1)'(signed'(33'sh1_8000_0000))) return 32'sh8000_0000;
		else return v[CW-1:0];
	endfunction

endpackage

>>> hdl/crps_front.sv
module crps_front import crps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,
	input  logic                 s_tlast,
	input  logic [THR_W-1:0]     thr,
	output logic                 push,
	output seg_job_t             job,
	input  logic                 full
);

	front_state_t state_q, state_d;
	coord_t [2:0] oldest_q, older_q, newer_q;
	logic [1:0]   held_q;
	seg_job_t     job_a_q, job_b_q, job_a_d, job_b_d;
	logic         two_q, two_d, has_a;
	coord_t [2:0] pt;
	logic         accept, bad;

	assign s_tready = (state_q == F_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign bad      = ({4'b0, thr} * 36'd10) < (36'd1 << FRAC_BITS);

	always_comb begin
		for (int a = 0; a < 3; a++) pt[a] = s_tdata[a*CW +: CW];
	end

	always_comb begin
		job_a_d = '0;
		job_b_d = '0;
		has_a   = 1'b0;
		two_d   = 1'b0;
		if (bad) begin
			has_a       = 1'b1;
			job_a_d.err = 1'b1;
			job_a_d.fin = 1'b1;
		end else if (held_q == 2'd1 && s_tlast) begin
			has_a       = 1'b1;
			job_a_d.fin = 1'b1;
			job_a_d.p0  = newer_q;
			job_a_d.p1  = pt;
			for (int a = 0; a < 3; a++) begin
				job_a_d.d0[a] = pt_sub(pt[a], newer_q[a]);
				job_a_d.d1[a] = pt_sub(pt[a], newer_q[a]);
			end
		end else if (held_q >= 2'd2) begin
			has_a       = 1'b1;
			two_d       = s_tlast;
			job_a_d.fin = !s_tlast;
			job_a_d.p0  = older_q;
			job_a_d.p1  = newer_q;
			job_b_d.fin = 1'b1;
			job_b_d.p0  = newer_q;
			job_b_d.p1  = pt;
			for (int a = 0; a < 3; a++) begin
				job_a_d.d0[a] = pt_sub(newer_q[a], (held_q == 2'd3) ? oldest_q[a] : older_q[a]);
				job_a_d.d1[a] = pt_sub(pt[a], older_q[a]);
				job_b_d.d0[a] = pt_sub(pt[a], older_q[a]);
				job_b_d.d1[a] = pt_sub(pt[a], newer_q[a]);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		job     = (state_q == F_PUSH_B) ? job_b_q : job_a_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept && has_a) state_d = F_PUSH_A;
			end
			F_PUSH_A: begin
				push = !full;
				if (!full) state_d = two_q ? F_PUSH_B : F_IDLE;
			end
			F_PUSH_B: begin
				push = !full;
				if (!full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			held_q   <= '0;
			oldest_q <= '0;
			older_q  <= '0;
			newer_q  <= '0;
			two_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				two_q <= two_d;
				if (s_tlast) begin
					held_q   <= '0;
					oldest_q <= '0;
					older_q  <= '0;
					newer_q  <= '0;
				end else if (!bad) begin
					oldest_q <= older_q;
					older_q  <= newer_q;
					newer_q  <= pt;
					if (held_q != 2'd3) held_q <= held_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_a_q <= job_a_d;
			job_b_q <= job_b_d;
		end
	end

endmodule

>>> hdl/crps_queue.sv
module crps_queue import crps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  seg_job_t wr_job,
	output logic     full,
	input  logic     pop,
	output seg_job_t rd_job,
	output logic     empty
);

	seg_job_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

>>> hdl/crps_div.sv
module crps_div import crps_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output fd_t                     res
);

	logic             busy_q, done_q, neg_q;
	logic [5:0]       cnt_q;
	logic [MAG_W-1:0] mag_q;
	logic [R_W-1:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [R_W:0]     r2;
	logic             ge;
	logic [NUM_W-1:0] num_abs;

	assign num_abs = num[NUM_W-1] ? -num : num;
	assign r2      = {rem_q, mag_q[MAG_W-1]};
	assign ge      = r2 >= {1'b0, den_q};
	assign done    = done_q;

	// floor division: remainder kept in [0, den)
	always_comb begin
		if (neg_q && rem_q != '0) begin
			res.q = -$signed({1'b0, mag_q}) - Q_W'(1);
			res.r = den_q - rem_q;
		end else if (neg_q) begin
			res.q = -$signed({1'b0, mag_q});
			res.r = '0;
		end else begin
			res.q = $signed({1'b0, mag_q});
			res.r = rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num_abs[MAG_W-1:0];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? R_W'(r2 - {1'b0, den_q}) : r2[R_W-1:0];
			mag_q <= {mag_q[MAG_W-2:0], ge};
		end
	end

endmodule

>>> hdl/crps_back.sv
module crps_back import crps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [THR_W-1:0]   thr,
	input  seg_job_t           job,
	input  logic               empty,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);

	back_state_t state_q, state_d;
	seg_job_t    job_q;

	logic [1:0]        ax_q;
	logic [2*CW-1:0]   prod_q;
	logic [SQ_W-1:0]   ssum_q, rad_q;
	logic [RT_W-1:0]   root_q;
	logic [RT_W+1:0]   srem_q;
	logic [5:0]        it_q;
	logic [RT_W:0]     cneed_q;
	logic [KT_W-1:0]   kt_q;
	logic [M_W-1:0]    m_q, j_q;
	logic [10:0]       m2_q;
	logic [15:0]       m3_q;
	logic [DEN_W-1:0]  den;

	logic signed [CO_W-1:0]  c2_q [3];
	logic signed [CO_W-1:0]  c3_q [3];
	logic signed [MUL_W-1:0] b_q  [3];
	logic signed [MUL_W-1:0] c_q  [3];
	logic signed [NUM_W-1:0] num_q [3][3];
	fd_t v_q [3], f1_q [3], f2_q [3], f3_q [3];

	logic [1:0] idx_q;
	logic       wait_q;
	logic       div_start;
	logic [2:0] div_done;
	fd_t        div_res [3];

	logic        ovalid_q, olast_q, obad_q;
	coord_t [2:0] odata_q;
	logic        ofree, fire, last_smp;

	diff_t           ax_diff;
	logic [CW-1:0]   ax_mag;
	logic [RT_W+3:0] rem2, trial;
	logic            kt_ok;

	assign den      = {m3_q, 1'b0};
	assign ofree    = !ovalid_q || m_tready;
	assign last_smp = (j_q == m_q - M_W'(1));
	assign kt_ok    = kt_q >= KT_W'(cneed_q);
	assign div_start = (state_q == B_DIV) && !wait_q;

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tlast  = olast_q;
	assign m_tuser  = obad_q;

	always_comb begin
		case (ax_q)
			2'd1:    ax_diff = pt_sub(job_q.p1[1], job_q.p0[1]);
			2'd2:    ax_diff = pt_sub(job_q.p1[2], job_q.p0[2]);
			default: ax_diff = pt_sub(job_q.p1[0], job_q.p0[0]);
		endcase
		ax_mag = ax_diff[DW-1] ? CW'(-ax_diff) : ax_diff[CW-1:0];
	end

	// square root, two radicand bits a step
	assign rem2  = {srem_q, rad_q[SQ_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_lane
			crps_div u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (div_start),
				.num    (num_q[g][idx_q]),
				.den    (den),
				.done   (div_done[g]),
				.res    (div_res[g])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		fire    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = job.err ? B_ERR : B_SUMSQ;
				end
			end
			B_ERR: begin
				fire = ofree;
				if (ofree) state_d = B_IDLE;
			end
			B_SUMSQ: if (ax_q == 2'd3) state_d = B_SQRT;
			B_SQRT:  if (it_q == 6'(RT_W - 1)) state_d = B_COUNT;
			B_COUNT: if (kt_ok || m_q == M_W'(MAX_SAMPLES)) state_d = B_COEF1;
			B_COEF1: state_d = B_COEF2;
			B_COEF2: state_d = B_COEF3;
			B_COEF3: state_d = B_DIV;
			B_DIV:   if (wait_q && div_done[0] && idx_q == 2'd2) state_d = B_EMIT;
			B_EMIT: begin
				fire = ofree;
				if (ofree && last_smp) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ovalid_q <= 1'b0;
			wait_q   <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q <= state_d;
			if (fire)          ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			if (div_start) begin
				wait_q <= 1'b1;
			end else if (wait_q && div_done[0]) begin
				wait_q <= 1'b0;
				idx_q  <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= job;
			ax_q   <= '0;
			ssum_q <= '0;
		end
		if (state_q == B_SUMSQ) begin
			ax_q <= ax_q + 2'd1;
			if (ax_q != 2'd3) prod_q <= ax_mag * ax_mag;
			if (ax_q != 2'd0) ssum_q <= ssum_q + SQ_W'(prod_q);
			if (ax_q == 2'd3) begin
				rad_q  <= ssum_q + SQ_W'(prod_q);
				root_q <= '0;
				srem_q <= '0;
				it_q   <= '0;
			end
		end
		if (state_q == B_SQRT) begin
			it_q  <= it_q + 6'd1;
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (rem2 >= trial) begin
				srem_q <= (RT_W+2)'(rem2 - trial);
				root_q <= {root_q[RT_W-2:0], 1'b1};
			end else begin
				srem_q <= rem2[RT_W+1:0];
				root_q <= {root_q[RT_W-2:0], 1'b0};
			end
			if (it_q == 6'(RT_W - 1)) begin
				// round the root up unless the square was exact
				cneed_q <= {1'b0, root_q[RT_W-2:0], (rem2 >= trial)}
					+ (RT_W+1)'(((rem2 >= trial) ? (rem2 - trial) : rem2) != '0);
				kt_q    <= KT_W'(thr) * KT_W'(MIN_SAMPLES);
				m_q     <= M_W'(MIN_SAMPLES);
			end
		end
		if (state_q == B_COUNT && !(kt_ok || m_q == M_W'(MAX_SAMPLES))) begin
			kt_q <= kt_q + KT_W'(thr);
			m_q  <= m_q + M_W'(1);
		end
		if (state_q == B_COEF1) begin
			m2_q <= 11'(m_q * m_q);
			for (int a = 0; a < 3; a++) begin
				c3_q[a] <= (CO_W'($signed(job_q.p0[a])) <<< 2) + CO_W'($signed(job_q.d0[a]))
					- (CO_W'($signed(job_q.p1[a])) <<< 2) + CO_W'($signed(job_q.d1[a]));
				c2_q[a] <= CO_W'($signed(job_q.p1[a])) * CO_W'(6)
					- CO_W'($signed(job_q.p0[a])) * CO_W'(6)
					- (CO_W'($signed(job_q.d0[a])) <<< 1) - CO_W'($signed(job_q.d1[a]));
			end
		end
		if (state_q == B_COEF2) begin
			m3_q <= 16'(m2_q * m_q);
			for (int a = 0; a < 3; a++) begin
				b_q[a] <= MUL_W'(c2_q[a]) * MUL_W'($signed({1'b0, m_q}));
				c_q[a] <= MUL_W'($signed(job_q.d0[a])) * MUL_W'($signed({1'b0, m2_q}));
			end
		end
		if (state_q == B_COEF3) begin
			for (int a = 0; a < 3; a++) begin
				num_q[a][0] <= NUM_W'(c3_q[a]) + NUM_W'(b_q[a]) + NUM_W'(c_q[a]);
				num_q[a][1] <= NUM_W'(c3_q[a]) * NUM_W'(6) + (NUM_W'(b_q[a]) <<< 1);
				num_q[a][2] <= NUM_W'(c3_q[a]) * NUM_W'(6);
			end
		end
		if (state_q == B_DIV && wait_q && div_done[0]) begin
			for (int a = 0; a < 3; a++) begin
				case (idx_q)
					2'd0:    f1_q[a] <= div_res[a];
					2'd1:    f2_q[a] <= div_res[a];
					default: f3_q[a] <= div_res[a];
				endcase
				v_q[a].q <= Q_W'($signed(job_q.p0[a]));
				v_q[a].r <= '0;
			end
			j_q <= '0;
		end
		if (fire) begin
			olast_q <= (state_q == B_ERR) || (last_smp && job_q.fin);
			obad_q  <= (state_q == B_ERR);
			for (int a = 0; a < 3; a++) begin
				if (state_q == B_ERR) odata_q[a] <= '0;
				else odata_q[a] <= sat_coord((Q_W+1)'(v_q[a].q)
					+ (Q_W+1)'(v_q[a].r >= {1'b0, m3_q}));
			end
		end
		if (fire && state_q == B_EMIT) begin
			j_q <= j_q + M_W'(1);
			for (int a = 0; a < 3; a++) begin
				v_q[a]  <= fd_add(v_q[a], f1_q[a], den);
				f1_q[a] <= fd_add(f1_q[a], f2_q[a], den);
				f2_q[a] <= fd_add(f2_q[a], f3_q[a], den);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_EMIT |-> m_q >= M_W'(MIN_SAMPLES) && m_q <= M_W'(MAX_SAMPLES))
		else $error("sample count out of range");

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		div_done[0] == div_done[1] && div_done[1] == div_done[2])
		else $error("divider lanes out of step");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && obad_q |-> olast_q && odata_q == '0)
		else $error("error beat malformed");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == B_IDLE && !wait_q)
		else $error("job taken while busy");

endmodule

>>> hdl/catmull_rom_path_sampler_unit.sv
// catmull-rom path sampler
// slave side takes one path point per beat: tdata holds x, y, z (signed fixed point),
// tlast marks the final point of a path. master side gives one sample per beat with
// tlast on the last sample caused by a point and tuser flagging a bad spacing value.
// cfg_we/cfg_wdata load the spacing threshold; write it only while the block is idle.
// the front holds the last three points and turns each point into up to two segment
// jobs, parked in a two-entry queue; the back evaluates the jobs one at a time.
// per segment the back takes the job, sums the squares, takes the square root, searches
// the sample count, works out the coefficients and runs three divisions in turn in the
// three divider lanes, then gives one sample per cycle while the receiver takes them
// (m = 10..32 samples).
// reset clears the held points, the queue and the output, and loads the threshold
// with its default. when the receiver stalls the output beat holds and the back
// waits; the queue then fills and the slave side deasserts tready.
module catmull_rom_path_sampler_unit import crps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // point_x, point_y, point_z
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // sample_x, sample_y, sample_z
	output logic               m_tlast,
	output logic               m_tuser,   // bad_spacing
	input  logic               cfg_we,
	input  logic [THR_W-1:0]   cfg_wdata
);

	logic [THR_W-1:0] thr_q;
	logic             push, full, pop, empty;
	seg_job_t         wr_job, rd_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RESET;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	crps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.thr      (thr_q),
		.push     (push),
		.job      (wr_job),
		.full     (full)
	);

	crps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	crps_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (thr_q),
		.job      (rd_job),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
